/* rtl/core/smlm_pkg.sv */
// ----------------------------------------------------------------------------
// smlm_pkg
// Character codes, field widths and character-class helpers shared by the
// self-move line matcher.
// ----------------------------------------------------------------------------
package smlm_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;

    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_B       = 8'h62;
    localparam logic [BYTE_W-1:0] CH_L       = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_M       = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_O       = 8'h6F;
    localparam logic [BYTE_W-1:0] CH_Q       = 8'h71;
    localparam logic [BYTE_W-1:0] CH_V       = 8'h76;
    localparam logic [BYTE_W-1:0] CH_W       = 8'h77;

    function automatic logic f_is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic f_is_alnum(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic f_is_term(input logic [BYTE_W-1:0] c);
        return (c == CH_NEWLINE) || (c == CH_NUL);
    endfunction

    function automatic logic f_is_suffix(input logic [BYTE_W-1:0] c);
        return (c == CH_Q) || (c == CH_L) || (c == CH_W) || (c == CH_B);
    endfunction

endpackage

/* rtl/core/self_move_line_matcher.sv */
// ----------------------------------------------------------------------------
// self_move_line_matcher
// Parses one assembly text line a byte per request and reports whether it
// is a register move to itself, with a saturating count of such lines.
// ----------------------------------------------------------------------------
// Result path: a line's final byte is accepted into the input register, then
//   the parse logic writes the line's result into the result register.
// Throughput: one byte per cycle; a final byte waits in the input register
//   only while an earlier result is held unaccepted at the output.
// Reset: synchronous active low; clears the parser, count and both valids.
//   The name buffer has no reset.
module self_move_line_matcher
    import smlm_pkg::*;
#(
    parameter int MAX_NAME_CHARS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_text_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_self_move,
    output logic [COUNT_W-1:0] o_match_total
);

    localparam int IDX_W = $clog2(MAX_NAME_CHARS);
    localparam int LEN_W = $clog2(MAX_NAME_CHARS + 2);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_NAME_CHARS);

    typedef enum logic [3:0] {
        PH_TAB, PH_M, PH_O, PH_V, PH_SUFFIX, PH_BLANKREQ, PH_BLANKS1,
        PH_N1FIRST, PH_N1, PH_BLANKS2, PH_N2FIRST, PH_N2, PH_TRAIL, PH_DONE
    } t_phase;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_end;

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_pos, n_pos;
    logic               r_differ, n_differ;
    logic               r_match, n_match;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0]  r_name [MAX_NAME_CHARS];

    logic               r_out_valid;
    logic               r_out_hit;
    logic [COUNT_W-1:0] r_out_total;

    logic               advance;
    logic               store;
    logic               cmp;
    logic               do_decide;
    logic               hit;
    logic [BYTE_W-1:0]  name_rd;

    function automatic logic f_ok(input logic [LEN_W-1:0] len,
                                  input logic [LEN_W-1:0] pos,
                                  input logic             differ);
        return (len <= MAX_LEN) && !differ && (pos == len) && (len != '0);
    endfunction

    assign advance = r_in_valid && (!r_end || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign name_rd = r_name[r_pos[IDX_W-1:0]];

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_pos     = r_pos;
        n_differ  = r_differ;
        n_match   = r_match;
        store     = 1'b0;
        cmp       = 1'b0;
        do_decide = 1'b0;
        unique case (r_phase)
            PH_TAB:      n_phase = (r_byte == CH_TAB) ? PH_M : PH_DONE;
            PH_M:        n_phase = (r_byte == CH_M) ? PH_O : PH_DONE;
            PH_O:        n_phase = (r_byte == CH_O) ? PH_V : PH_DONE;
            PH_V:        n_phase = (r_byte == CH_V) ? PH_SUFFIX : PH_DONE;
            PH_SUFFIX: begin
                if (f_is_suffix(r_byte)) n_phase = PH_BLANKREQ;
                else if (f_is_blank(r_byte)) n_phase = PH_BLANKS1;
                else n_phase = PH_DONE;
            end
            PH_BLANKREQ: n_phase = f_is_blank(r_byte) ? PH_BLANKS1 : PH_DONE;
            PH_BLANKS1: begin
                if (r_byte == CH_PERCENT) n_phase = PH_N1FIRST;
                else if (!f_is_blank(r_byte)) n_phase = PH_DONE;
            end
            PH_N1FIRST: begin
                if (f_is_alnum(r_byte)) begin
                    store   = 1'b1;
                    n_phase = PH_N1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_N1: begin
                if (f_is_alnum(r_byte)) store = 1'b1;
                else if (r_byte == CH_COMMA) n_phase = PH_BLANKS2;
                else n_phase = PH_DONE;
            end
            PH_BLANKS2: begin
                if (r_byte == CH_PERCENT) begin
                    n_pos    = '0;
                    n_differ = 1'b0;
                    n_phase  = PH_N2FIRST;
                end else if (!f_is_blank(r_byte)) begin
                    n_phase = PH_DONE;
                end
            end
            PH_N2FIRST: begin
                if (f_is_alnum(r_byte)) begin
                    cmp     = 1'b1;
                    n_phase = PH_N2;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_N2: begin
                if (f_is_alnum(r_byte)) cmp = 1'b1;
                else if (f_is_blank(r_byte)) n_phase = PH_TRAIL;
                else if (f_is_term(r_byte)) do_decide = 1'b1;
                else n_phase = PH_DONE;
            end
            PH_TRAIL: begin
                if (f_is_term(r_byte)) do_decide = 1'b1;
                else if (!f_is_blank(r_byte)) n_phase = PH_DONE;
            end
            PH_DONE:     n_phase = PH_DONE;
            default:     n_phase = PH_DONE;
        endcase

        if (store && (r_len <= MAX_LEN)) n_len = r_len + 1'b1;
        if (cmp) begin
            if ((r_pos < r_len) && (r_pos < MAX_LEN)) begin
                if (name_rd != r_byte) n_differ = 1'b1;
            end else begin
                n_differ = 1'b1;
            end
            if (r_pos <= MAX_LEN) n_pos = r_pos + 1'b1;
        end

        if (do_decide) begin
            n_phase = PH_DONE;
            n_match = f_ok(n_len, n_pos, n_differ);
        end else if (n_phase == PH_DONE && r_phase != PH_DONE) begin
            n_match = 1'b0;
        end

        if (n_phase == PH_N2 || n_phase == PH_TRAIL) hit = f_ok(n_len, n_pos, n_differ);
        else if (n_phase != PH_DONE) hit = 1'b0;
        else hit = n_match;

        n_count = (r_end && hit && (r_count != '1)) ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_TAB;
            r_len       <= '0;
            r_pos       <= '0;
            r_differ    <= 1'b0;
            r_match     <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
                r_byte     <= i_text_byte;
                r_end      <= i_text_end;
            end
            if (advance && r_end) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= hit;
                r_out_total <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_count <= n_count;
                if (r_end) begin
                    r_phase  <= PH_TAB;
                    r_len    <= '0;
                    r_pos    <= '0;
                    r_differ <= 1'b0;
                    r_match  <= 1'b0;
                end else begin
                    r_phase  <= n_phase;
                    r_len    <= n_len;
                    r_pos    <= n_pos;
                    r_differ <= n_differ;
                    r_match  <= n_match;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && store && (r_len < MAX_LEN)) begin
            r_name[r_len[IDX_W-1:0]] <= r_byte;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_self_move = r_out_hit;
    assign o_match_total  = r_out_total;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MAX_LEN + 1'b1)
        else $error("name length beyond bound");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_LEN + 1'b1)
        else $error("compare position beyond bound");

    a_match_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE) |-> !r_match)
        else $error("match verdict held outside done phase");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_self_move) |-> (o_match_total != '0))
        else $error("match reported with zero total");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("match count decreased");
`endif

endmodule
